FILE: sv/pmo_pkg.sv
// Shared constants and types for the polygon corner miter offset block.
// No dependencies; the square root cell and the top level refer to it by scoped names.
package pmo_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int RESULT_WIDTH_DEF = 24;

  localparam int OFF_W          = 16;               // offset distance, Q8.8
  localparam int NORM_W         = 16;               // edge magnitudes after normalising
  localparam int RAD_SHIFT      = 24;
  localparam int SQ_ROOT_W      = 29;               // edge length, about |v| * 2^12
  localparam int SQ_RAD_W       = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W       = SQ_ROOT_W + 2;
  localparam int UNIT_NUM_SHIFT = 33;
  localparam int UNIT_FRAC      = 20;
  localparam int UDIV_Q_W       = UNIT_FRAC + 1;    // unit magnitude, at most 2^20
  localparam int UDIV_D_W       = SQ_ROOT_W + 1;    // twice the length
  localparam int UNIT_W         = UDIV_Q_W + 1;     // signed unit component
  localparam int DIFF_W         = UNIT_W + 1;
  localparam int PROD_W         = 2 * UNIT_W;
  localparam int DEN_W          = PROD_W + 2;
  localparam int CP_W           = OFF_W + DIFF_W;
  localparam int NUM_W          = CP_W + UNIT_FRAC + 2;
  localparam int RDIV_D_W       = 44;               // twice the denominator

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_EDGE = 2'd1,
    ST_ZERO_DEN  = 2'd2,
    ST_SAT       = 2'd3
  } status_e;

endpackage

FILE: sv/pmo_sqrt_cell.sv
// One step of the pipelined square root: one root bit per cell, lanes in step.
// Depends on pmo_pkg for the root, remainder and radicand widths.
module pmo_sqrt_cell #(
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [pmo_pkg::SQ_REM_W-1:0]  rem_i  [LANES],
  input  logic [pmo_pkg::SQ_ROOT_W-1:0] root_i [LANES],
  input  logic [pmo_pkg::SQ_RAD_W-1:0]  rad_i  [LANES],
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [pmo_pkg::SQ_REM_W-1:0]  rem_o  [LANES],
  output logic [pmo_pkg::SQ_ROOT_W-1:0] root_o [LANES],
  output logic [pmo_pkg::SQ_RAD_W-1:0]  rad_o  [LANES],
  output logic [SIDE_W-1:0]             side_o
);

  logic                          valid_q;
  logic [pmo_pkg::SQ_REM_W-1:0]  rem_d  [LANES];
  logic [pmo_pkg::SQ_ROOT_W-1:0] root_d [LANES];
  logic [pmo_pkg::SQ_REM_W-1:0]  rem_q  [LANES];
  logic [pmo_pkg::SQ_ROOT_W-1:0] root_q [LANES];
  logic [pmo_pkg::SQ_RAD_W-1:0]  rad_q  [LANES];
  logic [SIDE_W-1:0]             side_q;
  logic                          take;

  assign ready_o = ~valid_q | ready_i;
  assign take    = valid_i & ready_o;

  always_comb begin
    logic [pmo_pkg::SQ_REM_W-1:0] t;
    logic [pmo_pkg::SQ_REM_W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      // bring down the next two radicand bits, try root*4 + 1
      t     = {rem_i[l][pmo_pkg::SQ_REM_W-3:0], rad_i[l][pmo_pkg::SQ_RAD_W-1 -: 2]};
      trial = {root_i[l], 2'b01};
      if (t >= trial) begin
        rem_d[l]  = t - trial;
        root_d[l] = {root_i[l][pmo_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[l]  = t;
        root_d[l] = {root_i[l][pmo_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l]  <= rem_d[l];
        root_q[l] <= root_d[l];
        rad_q[l]  <= rad_i[l] << 2;
      end
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

FILE: sv/pmo_div_cell.sv
// One step of the pipelined restoring divider: one quotient bit per cell.
// Numerator bits still to come and quotient bits share one shift register.
module pmo_div_cell #(
  parameter int LANES  = 2,
  parameter int D_W    = 30,
  parameter int Q_W    = 21,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [D_W-1:0]    rem_i [LANES],
  input  logic [Q_W-1:0]    nq_i  [LANES],
  input  logic [D_W-1:0]    div_i [LANES],
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [D_W-1:0]    rem_o [LANES],
  output logic [Q_W-1:0]    nq_o  [LANES],
  output logic [D_W-1:0]    div_o [LANES],
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q;
  logic [D_W-1:0]    rem_d [LANES];
  logic [Q_W-1:0]    nq_d  [LANES];
  logic [D_W-1:0]    rem_q [LANES];
  logic [Q_W-1:0]    nq_q  [LANES];
  logic [D_W-1:0]    div_q [LANES];
  logic [SIDE_W-1:0] side_q;
  logic              take;

  assign ready_o = ~valid_q | ready_i;
  assign take    = valid_i & ready_o;

  always_comb begin
    logic [D_W:0] t;
    logic [D_W:0] diff;
    logic         ge;
    for (int l = 0; l < LANES; l++) begin
      t    = {rem_i[l], nq_i[l][Q_W-1]};
      diff = t - {1'b0, div_i[l]};
      ge   = t >= {1'b0, div_i[l]};
      rem_d[l] = ge ? diff[D_W-1:0] : t[D_W-1:0];
      nq_d[l]  = {nq_i[l][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

FILE: sv/polygon_corner_miter_offset.sv
// Polygon corner miter offset: top level, front and back stages, cell chains.
// Depends on pmo_pkg, pmo_sqrt_cell and pmo_div_cell.
//
//  channel | dir | fields (lowest bits first)
//  s_axis  | in  | tdata: corner_x, corner_y, first_neighbor_x, first_neighbor_y,
//          |     |        second_neighbor_x, second_neighbor_y, offset_distance
//  m_axis  | out | tdata: offset_x, offset_y; tuser: status
//
// One beat per cycle sustained while the output is not stalled. The pipeline runs through
// the front stages, the square root cells, one root bit each, the unit divider chain and
// the result divider chain, one quotient bit per cell, and the back stages.
// Reset clears only the stage valid bits.
// A stall holds each full stage; ready ripples back so bubbles close up and
// input keeps flowing until every stage is full.
module polygon_corner_miter_offset #(
  parameter int COORD_WIDTH  = pmo_pkg::COORD_WIDTH_DEF,
  parameter int RESULT_WIDTH = pmo_pkg::RESULT_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // corner_x, corner_y, first_neighbor_x, first_neighbor_y,
  // second_neighbor_x, second_neighbor_y, offset_distance, zero fill
  input  logic [((6*COORD_WIDTH+pmo_pkg::OFF_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // offset_x, offset_y, zero fill
  output logic [((2*RESULT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [1:0]              m_axis_tuser
);

  localparam int CW     = COORD_WIDTH;
  localparam int RW     = RESULT_WIDTH;
  localparam int OW     = pmo_pkg::OFF_W;
  localparam int NW     = pmo_pkg::NORM_W;
  localparam int EW     = (CW > NW) ? CW : NW;
  localparam int SHMAX  = EW - NW;
  localparam int SHW    = $clog2(SHMAX + 2);
  localparam int SQN    = pmo_pkg::SQ_ROOT_W;
  localparam int UDN    = pmo_pkg::UDIV_Q_W;
  localparam int OUT_TW = ((2*RW+7)/8)*8;
  localparam int SIDE1_W = OW + 1 + 4 + 4*NW;
  localparam int SIDE2_W = OW + 1 + 4;
  localparam int SIDE3_W = 6;
  localparam int NSH    = pmo_pkg::NUM_W - RW;
  localparam int CMPW   = (NSH > pmo_pkg::RDIV_D_W) ? NSH : pmo_pkg::RDIV_D_W;
  localparam int NST    = 10;
  localparam int ST_B = 1, ST_C = 2, ST_D = 3, ST_E = 4, ST_F = 5;
  localparam int ST_G = 6, ST_H = 7, ST_I = 8, ST_O = 9;
  localparam logic signed [pmo_pkg::DEN_W-1:0] DenOne =
    pmo_pkg::DEN_W'(64'd1 << (2*pmo_pkg::UNIT_FRAC));
  localparam logic [RW-1:0] Lim    = RW'(1) << (RW-1);
  localparam logic [RW-1:0] SatPos = Lim - RW'(1);

  // stage handshake
  logic [NST-1:0] v_q, iv, dr, rdy, take;
  assign rdy = ~v_q | dr;
  assign take = iv & rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= iv[k];
      end
    end
  end

  // chain wiring
  logic                          sq_v   [SQN+1];
  logic                          sq_rdy [SQN+1];
  logic [pmo_pkg::SQ_REM_W-1:0]  sq_rem [SQN+1][2];
  logic [pmo_pkg::SQ_ROOT_W-1:0] sq_root[SQN+1][2];
  logic [pmo_pkg::SQ_RAD_W-1:0]  sq_rad [SQN+1][2];
  logic [SIDE1_W-1:0]            sq_side[SQN+1];

  logic                          ud_v   [UDN+1];
  logic                          ud_rdy [UDN+1];
  logic [pmo_pkg::UDIV_D_W-1:0]  ud_rem [UDN+1][4];
  logic [UDN-1:0]                ud_nq  [UDN+1][4];
  logic [pmo_pkg::UDIV_D_W-1:0]  ud_div [UDN+1][4];
  logic [SIDE2_W-1:0]            ud_side[UDN+1];

  logic                          rd_v   [RW+1];
  logic                          rd_rdy [RW+1];
  logic [pmo_pkg::RDIV_D_W-1:0]  rd_rem [RW+1][2];
  logic [RW-1:0]                 rd_nq  [RW+1][2];
  logic [pmo_pkg::RDIV_D_W-1:0]  rd_div [RW+1][2];
  logic [SIDE3_W-1:0]            rd_side[RW+1];

  assign iv[0]    = s_axis_tvalid;
  assign iv[ST_B] = v_q[0];
  assign iv[ST_C] = v_q[ST_B];
  assign iv[ST_D] = v_q[ST_C];
  assign iv[ST_E] = ud_v[UDN];
  assign iv[ST_F] = v_q[ST_E];
  assign iv[ST_G] = v_q[ST_F];
  assign iv[ST_H] = v_q[ST_G];
  assign iv[ST_I] = v_q[ST_H];
  assign iv[ST_O] = rd_v[RW];

  assign dr[0]    = rdy[ST_B];
  assign dr[ST_B] = rdy[ST_C];
  assign dr[ST_C] = rdy[ST_D];
  assign dr[ST_D] = sq_rdy[0];
  assign dr[ST_E] = rdy[ST_F];
  assign dr[ST_F] = rdy[ST_G];
  assign dr[ST_G] = rdy[ST_H];
  assign dr[ST_H] = rdy[ST_I];
  assign dr[ST_I] = rd_rdy[0];
  assign dr[ST_O] = m_axis_tready;

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[ST_O];

  // A: edge vectors corner - neighbour
  logic signed [CW:0]   a_ex_q [2];
  logic signed [CW:0]   a_ey_q [2];
  logic signed [OW-1:0] a_c_q;

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      for (int e = 0; e < 2; e++) begin
        a_ex_q[e] <= (CW+1)'($signed(s_axis_tdata[0 +: CW]))
                   - (CW+1)'($signed(s_axis_tdata[(2+2*e)*CW +: CW]));
        a_ey_q[e] <= (CW+1)'($signed(s_axis_tdata[CW +: CW]))
                   - (CW+1)'($signed(s_axis_tdata[(3+2*e)*CW +: CW]));
      end
      a_c_q <= $signed(s_axis_tdata[6*CW +: OW]);
    end
  end

  // B: magnitudes, signs, shift both down below 2^16
  logic [NW-1:0] b_mx_d [2], b_my_d [2];
  logic [3:0]    b_sgn_d;
  logic          b_zero_d;
  logic [NW-1:0] b_mx_q [2], b_my_q [2];
  logic [3:0]    b_sgn_q;
  logic          b_zero_q;
  logic signed [OW-1:0] b_c_q;

  always_comb begin
    logic [CW:0]    nx, ny;
    logic [EW-1:0]  mx, my, mor;
    logic [SHW-1:0] sh;
    b_zero_d = 1'b0;
    for (int e = 0; e < 2; e++) begin
      nx = -a_ex_q[e];
      ny = -a_ey_q[e];
      mx = EW'(a_ex_q[e][CW] ? nx[CW-1:0] : a_ex_q[e][CW-1:0]);
      my = EW'(a_ey_q[e][CW] ? ny[CW-1:0] : a_ey_q[e][CW-1:0]);
      mor = mx | my;
      sh = '0;
      for (int k = SHMAX; k >= 0; k--) begin
        if (({1'b0, mor} >> k) < ((EW+1)'(1) << NW)) sh = SHW'(k);
      end
      b_mx_d[e] = NW'(mx >> sh);
      b_my_d[e] = NW'(my >> sh);
      b_sgn_d[2*e]   = a_ex_q[e][CW];
      b_sgn_d[2*e+1] = a_ey_q[e][CW];
      if (a_ex_q[e] == '0 && a_ey_q[e] == '0) b_zero_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[ST_B]) begin
      b_mx_q   <= b_mx_d;
      b_my_q   <= b_my_d;
      b_sgn_q  <= b_sgn_d;
      b_zero_q <= b_zero_d;
      b_c_q    <= a_c_q;
    end
  end

  // C: squares
  logic [2*NW-1:0] c_sqx_q [2], c_sqy_q [2];
  logic [NW-1:0]   c_mx_q [2], c_my_q [2];
  logic [3:0]      c_sgn_q;
  logic            c_zero_q;
  logic signed [OW-1:0] c_c_q;

  always_ff @(posedge clk_i) begin
    if (take[ST_C]) begin
      for (int e = 0; e < 2; e++) begin
        c_sqx_q[e] <= b_mx_q[e] * b_mx_q[e];
        c_sqy_q[e] <= b_my_q[e] * b_my_q[e];
      end
      c_mx_q   <= b_mx_q;
      c_my_q   <= b_my_q;
      c_sgn_q  <= b_sgn_q;
      c_zero_q <= b_zero_q;
      c_c_q    <= b_c_q;
    end
  end

  // D: radicand (x*x + y*y) << 24
  logic [pmo_pkg::SQ_RAD_W-1:0] d_rad_q [2];
  logic [SIDE1_W-1:0]           d_side_q;

  always_ff @(posedge clk_i) begin
    if (take[ST_D]) begin
      for (int e = 0; e < 2; e++) begin
        d_rad_q[e] <= pmo_pkg::SQ_RAD_W'({1'b0, c_sqx_q[e]} + {1'b0, c_sqy_q[e]})
                      << pmo_pkg::RAD_SHIFT;
      end
      d_side_q <= {c_c_q, c_zero_q, c_sgn_q, c_mx_q[0], c_my_q[0], c_mx_q[1], c_my_q[1]};
    end
  end

  // square root chain, both edges as lanes
  assign sq_v[0]    = v_q[ST_D];
  assign sq_side[0] = d_side_q;
  for (genvar e = 0; e < 2; e++) begin : g_sq_in
    assign sq_rem[0][e]  = '0;
    assign sq_root[0][e] = '0;
    assign sq_rad[0][e]  = d_rad_q[e];
  end

  for (genvar k = 0; k < SQN; k++) begin : g_sq
    pmo_sqrt_cell #(
      .LANES  (2),
      .SIDE_W (SIDE1_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[k]),
      .ready_o (sq_rdy[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .rad_i   (sq_rad[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_v[k+1]),
      .ready_i (sq_rdy[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .rad_o   (sq_rad[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // unit divider setup: (m << 33 + len) / (2 * len); bits split, no adder needed
  logic [NW-1:0] ud_m [4];
  assign ud_m[0] = sq_side[SQN][4*NW-1 -: NW];
  assign ud_m[1] = sq_side[SQN][3*NW-1 -: NW];
  assign ud_m[2] = sq_side[SQN][2*NW-1 -: NW];
  assign ud_m[3] = sq_side[SQN][NW-1:0];

  assign sq_rdy[SQN] = ud_rdy[0];
  assign ud_v[0]     = sq_v[SQN];
  assign ud_side[0]  = sq_side[SQN][SIDE1_W-1 -: SIDE2_W];
  for (genvar l = 0; l < 4; l++) begin : g_ud_in
    assign ud_rem[0][l] =
      (pmo_pkg::UDIV_D_W'(ud_m[l]) << (pmo_pkg::UNIT_NUM_SHIFT - UDN))
      | pmo_pkg::UDIV_D_W'(sq_root[SQN][l/2] >> UDN);
    assign ud_nq[0][l]  = sq_root[SQN][l/2][UDN-1:0];
    assign ud_div[0][l] = {sq_root[SQN][l/2], 1'b0};
  end

  for (genvar k = 0; k < UDN; k++) begin : g_ud
    pmo_div_cell #(
      .LANES  (4),
      .D_W    (pmo_pkg::UDIV_D_W),
      .Q_W    (UDN),
      .SIDE_W (SIDE2_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ud_v[k]),
      .ready_o (ud_rdy[k]),
      .rem_i   (ud_rem[k]),
      .nq_i    (ud_nq[k]),
      .div_i   (ud_div[k]),
      .side_i  (ud_side[k]),
      .valid_o (ud_v[k+1]),
      .ready_i (ud_rdy[k+1]),
      .rem_o   (ud_rem[k+1]),
      .nq_o    (ud_nq[k+1]),
      .div_o   (ud_div[k+1]),
      .side_o  (ud_side[k+1])
    );
  end
  assign ud_rdy[UDN] = rdy[ST_E];

  // E: signed unit components, lanes d1x, d1y, d2x, d2y
  logic signed [pmo_pkg::UNIT_W-1:0] e_u_q [4];
  logic signed [OW-1:0]              e_c_q;
  logic                              e_zero_q, e_cz_q;

  always_ff @(posedge clk_i) begin
    if (take[ST_E]) begin
      for (int l = 0; l < 4; l++) begin
        e_u_q[l] <= ud_side[UDN][l] ? -$signed({1'b0, ud_nq[UDN][l]})
                                    :  $signed({1'b0, ud_nq[UDN][l]});
      end
      e_c_q    <= $signed(ud_side[UDN][SIDE2_W-1 -: OW]);
      e_zero_q <= ud_side[UDN][4];
      e_cz_q   <= ud_side[UDN][SIDE2_W-1 -: OW] == '0;
    end
  end

  // F: dot product terms and normal differences
  logic signed [pmo_pkg::PROD_W-1:0] f_p_q [2];
  logic signed [pmo_pkg::DIFF_W-1:0] f_dy_q, f_dx_q;
  logic signed [OW-1:0]              f_c_q;
  logic                              f_zero_q, f_cz_q;

  always_ff @(posedge clk_i) begin
    if (take[ST_F]) begin
      f_p_q[0] <= e_u_q[0] * e_u_q[2];
      f_p_q[1] <= e_u_q[1] * e_u_q[3];
      f_dy_q   <= pmo_pkg::DIFF_W'(e_u_q[3]) - pmo_pkg::DIFF_W'(e_u_q[1]);
      f_dx_q   <= pmo_pkg::DIFF_W'(e_u_q[0]) - pmo_pkg::DIFF_W'(e_u_q[2]);
      f_c_q    <= e_c_q;
      f_zero_q <= e_zero_q;
      f_cz_q   <= e_cz_q;
    end
  end

  // G: denominator 1 - d1.d2 in Q.40, and c times the differences
  logic signed [pmo_pkg::DEN_W-1:0] g_den_q;
  logic signed [pmo_pkg::CP_W-1:0]  g_cp_q [2];
  logic                             g_zero_q, g_cz_q;

  always_ff @(posedge clk_i) begin
    if (take[ST_G]) begin
      g_den_q  <= DenOne - pmo_pkg::DEN_W'(f_p_q[0]) - pmo_pkg::DEN_W'(f_p_q[1]);
      g_cp_q[0] <= f_c_q * f_dy_q;
      g_cp_q[1] <= f_c_q * f_dx_q;
      g_zero_q <= f_zero_q;
      g_cz_q   <= f_cz_q;
    end
  end

  // H: magnitudes, zero-denominator flag (also set for a negative denominator or a zero offset)
  logic [pmo_pkg::CP_W-1:0]         h_mag_q [2];
  logic [1:0]                       h_neg_q;
  logic signed [pmo_pkg::DEN_W-1:0] h_den_q;
  logic                             h_zero_q, h_zden_q;

  always_ff @(posedge clk_i) begin
    if (take[ST_H]) begin
      for (int l = 0; l < 2; l++) begin
        h_mag_q[l] <= g_cp_q[l][pmo_pkg::CP_W-1] ? pmo_pkg::CP_W'(-g_cp_q[l])
                                                 : pmo_pkg::CP_W'(g_cp_q[l]);
        h_neg_q[l] <= g_cp_q[l][pmo_pkg::CP_W-1];
      end
      h_den_q  <= g_den_q;
      h_zero_q <= g_zero_q;
      h_zden_q <= g_cz_q | g_den_q[pmo_pkg::DEN_W-1] | (g_den_q == '0);
    end
  end

  // I: result divider setup, rounding numerator 2m + den over 2 den
  logic [pmo_pkg::RDIV_D_W-1:0] i_rem_d [2], i_div_d;
  logic [RW-1:0]                i_nq_d [2];
  logic [1:0]                   i_ovf_d;
  logic [pmo_pkg::RDIV_D_W-1:0] i_rem_q [2], i_div_q [2];
  logic [RW-1:0]                i_nq_q [2];
  logic [SIDE3_W-1:0]           i_side_q;

  always_comb begin
    logic [pmo_pkg::NUM_W-1:0] num;
    logic [CMPW-1:0]           top;
    i_div_d = pmo_pkg::RDIV_D_W'($unsigned(h_den_q) << 1);
    for (int l = 0; l < 2; l++) begin
      num = (pmo_pkg::NUM_W'(h_mag_q[l]) << (pmo_pkg::UNIT_FRAC + 1))
          + pmo_pkg::NUM_W'($unsigned(h_den_q));
      top = CMPW'(num >> RW);
      // quotient would not fit RW bits: saturates anyway
      i_ovf_d[l] = top >= CMPW'(i_div_d);
      i_rem_d[l] = pmo_pkg::RDIV_D_W'(top);
      i_nq_d[l]  = num[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[ST_I]) begin
      i_rem_q  <= i_rem_d;
      i_nq_q   <= i_nq_d;
      i_div_q[0] <= i_div_d;
      i_div_q[1] <= i_div_d;
      i_side_q <= {i_ovf_d, h_neg_q, h_zden_q, h_zero_q};
    end
  end

  assign rd_v[0]    = v_q[ST_I];
  assign rd_side[0] = i_side_q;
  assign rd_rem[0]  = i_rem_q;
  assign rd_nq[0]   = i_nq_q;
  assign rd_div[0]  = i_div_q;

  for (genvar k = 0; k < RW; k++) begin : g_rd
    pmo_div_cell #(
      .LANES  (2),
      .D_W    (pmo_pkg::RDIV_D_W),
      .Q_W    (RW),
      .SIDE_W (SIDE3_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rd_v[k]),
      .ready_o (rd_rdy[k]),
      .rem_i   (rd_rem[k]),
      .nq_i    (rd_nq[k]),
      .div_i   (rd_div[k]),
      .side_i  (rd_side[k]),
      .valid_o (rd_v[k+1]),
      .ready_i (rd_rdy[k+1]),
      .rem_o   (rd_rem[k+1]),
      .nq_o    (rd_nq[k+1]),
      .div_o   (rd_div[k+1]),
      .side_o  (rd_side[k+1])
    );
  end
  assign rd_rdy[RW] = rdy[ST_O];

  // O: sign, saturation, status; this is the output register
  logic [RW-1:0]            o_val_d [2];
  pmo_pkg::status_e         o_st_d;
  logic [RW-1:0]            o_val_q [2];
  pmo_pkg::status_e         o_st_q;

  always_comb begin
    logic [RW-1:0] q;
    logic          sat, neg, ovf;
    sat = 1'b0;
    for (int l = 0; l < 2; l++) begin
      q   = rd_nq[RW][l];
      neg = rd_side[RW][2+l];
      ovf = rd_side[RW][4+l];
      if (neg) begin
        if (ovf || q > Lim) begin
          q   = Lim;
          sat = 1'b1;
        end
        o_val_d[l] = -q;
      end else begin
        if (ovf || q > SatPos) begin
          q   = SatPos;
          sat = 1'b1;
        end
        o_val_d[l] = q;
      end
    end
    priority if (rd_side[RW][0]) begin
      o_st_d     = pmo_pkg::ST_ZERO_EDGE;
      o_val_d[0] = '0;
      o_val_d[1] = '0;
    end else if (rd_side[RW][1]) begin
      o_st_d     = pmo_pkg::ST_ZERO_DEN;
      o_val_d[0] = '0;
      o_val_d[1] = '0;
    end else if (sat) begin
      o_st_d = pmo_pkg::ST_SAT;
    end else begin
      o_st_d = pmo_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[ST_O]) begin
      o_val_q <= o_val_d;
      o_st_q  <= o_st_d;
    end
  end

  assign m_axis_tdata = OUT_TW'({o_val_q[1], o_val_q[0]});
  assign m_axis_tuser = o_st_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_flag_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pmo_pkg::ST_ZERO_EDGE
                      || m_axis_tuser == pmo_pkg::ST_ZERO_DEN)
    |-> m_axis_tdata[2*RW-1:0] == '0)
    else $error("flagged beat carries a nonzero offset");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == pmo_pkg::ST_SAT
    |-> m_axis_tdata[RW-1:0] == SatPos || m_axis_tdata[RW-1:0] == Lim
        || m_axis_tdata[2*RW-1:RW] == SatPos || m_axis_tdata[2*RW-1:RW] == Lim)
    else $error("saturation flagged but no component at a limit");

endmodule
